// ===== rtl/core/depth_pixel_to_world_point_macros.svh =====
// assertion macros shared by the depth pixel to world point block
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_MACROS_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_MACROS_SVH
`ifndef ASSERT_OFF
`define DPW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DPW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DPW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DPW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dpw_pkg.sv =====
// package: widths, types and helper functions of the depth pixel to world point block
`timescale 1ns / 1ps
package dpw_pkg;

  localparam int POSE_FRAC_BITS_DEF = 16;
  localparam int COORD_BITS_DEF     = 12;

  localparam int CRD_W  = 14;
  localparam int DIFF_W = CRD_W + 5;
  localparam int MAG_W  = CRD_W + 4;
  localparam int PROD_W = MAG_W + 16;
  localparam int NUM_W  = PROD_W + 2;
  localparam int DEN_W  = 17;
  localparam int CAM_W  = 24;
  localparam int ACC_W  = 58;
  localparam int RCP_W  = 25;
  localparam int RCP_SH = 24;
  localparam int LANES  = 2;
  localparam int TW_N   = 12;

  localparam logic [2:0] REG_STEP  = 3'd0;
  localparam logic [2:0] REG_MIN_D = 3'd1;
  localparam logic [2:0] REG_MAX_D = 3'd2;
  localparam logic [2:0] REG_FX    = 3'd3;
  localparam logic [2:0] REG_FY    = 3'd4;
  localparam logic [2:0] REG_CX    = 3'd5;
  localparam logic [2:0] REG_CY    = 3'd6;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  localparam logic signed [CAM_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [CAM_W-1:0] SAT_MIN = -24'sh800000;

  typedef struct packed {
    logic        action;
    logic [3:0]  idx;
    logic [31:0] word;
    logic        keep;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } dpw_tag_t;

  // ceil(2^24 / d), exact floor division for coordinates below 2^14
  function automatic logic [RCP_W-1:0] dpw_recip(input logic [3:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      4'd10:   r = 25'd1677722;
      4'd11:   r = 25'd1525202;
      4'd12:   r = 25'd1398102;
      4'd13:   r = 25'd1290556;
      4'd14:   r = 25'd1198373;
      4'd15:   r = 25'd1118482;
      default: r = 25'd16777216;
    endcase
    return r;
  endfunction

  function automatic logic signed [CAM_W-1:0] dpw_sat(input logic signed [ACC_W-1:0] v);
    logic signed [CAM_W-1:0] r;
    if (v > ACC_W'(SAT_MAX)) r = SAT_MAX;
    else if (v < ACC_W'(SAT_MIN)) r = SAT_MIN;
    else r = CAM_W'(v);
    return r;
  endfunction

endpackage

// ===== rtl/core/dpw_if.sv =====
// request channel interfaces for pixels in and points out
`timescale 1ns / 1ps
interface dpw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] row;
  logic [11:0] col;
  logic [15:0] depth_mm;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [3:0]  pose_index;
  logic signed [31:0] pose_word;
  modport source(output valid, action, row, col, depth_mm, blue, green, red, pose_index,
                 pose_word, input ready);
  modport sink(input valid, action, row, col, depth_mm, blue, green, red, pose_index,
               pose_word, output ready);
endinterface

interface dpw_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] world_x;
  logic signed [23:0] world_y;
  logic signed [23:0] world_z;
  logic [7:0]  point_blue;
  logic [7:0]  point_green;
  logic [7:0]  point_red;
  modport source(output valid, world_x, world_y, world_z, point_blue, point_green,
                 point_red, input ready);
  modport sink(input valid, world_x, world_y, world_z, point_blue, point_green,
               point_red, output ready);
endinterface

// ===== rtl/core/dpw_front.sv =====
// front end: configuration registers, pixel filter and divider operand set-up
`timescale 1ns / 1ps
module dpw_front import dpw_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_v,
  input  logic              in_action,
  input  logic [11:0]       in_row,
  input  logic [11:0]       in_col,
  input  logic [15:0]       in_depth,
  input  logic [7:0]        in_blue,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_red,
  input  logic [3:0]        in_idx,
  input  logic [31:0]       in_word,
  output logic              out_v,
  output dpw_tag_t          out_tag,
  output logic [LANES-1:0][NUM_W-1:0] out_num,
  output logic [LANES-1:0][DEN_W-1:0] out_den
);

  localparam logic [CRD_W-1:0] CMASK = CRD_W'((1 << COORD_BITS) - 1);

  logic [3:0]  step_r;
  logic [15:0] min_d_r, max_d_r, fx_r, fy_r, cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 4'd3;
      min_d_r <= 16'd10;
      max_d_r <= 16'd5000;
      fx_r    <= 16'd8400;
      fy_r    <= 16'd8400;
      cx_r    <= 16'd5120;
      cy_r    <= 16'd3840;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:  step_r  <= cfg_data[3:0];
        REG_MIN_D: min_d_r <= cfg_data;
        REG_MAX_D: max_d_r <= cfg_data;
        REG_FX:    fx_r    <= cfg_data;
        REG_FY:    fy_r    <= cfg_data;
        REG_CX:    cx_r    <= cfg_data;
        REG_CY:    cy_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: quotient by the step, depth window, colour test, centred coordinates
  logic [3:0]       step_e;
  logic [RCP_W-1:0] rcp;
  logic [CRD_W-1:0] rowm, colm, qr_nxt, qc_nxt;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;

  always_comb begin
    step_e = (step_r == 4'd0) ? 4'd1 : step_r;
    rcp    = dpw_recip(step_e);
    rowm   = CRD_W'(in_row) & CMASK;
    colm   = CRD_W'(in_col) & CMASK;
    qr_nxt = CRD_W'(((CRD_W + RCP_W)'(rowm) * (CRD_W + RCP_W)'(rcp)) >> RCP_SH);
    qc_nxt = CRD_W'(((CRD_W + RCP_W)'(colm) * (CRD_W + RCP_W)'(rcp)) >> RCP_SH);
    dx_nxt = signed'(DIFF_W'({colm, 4'b0000})) - signed'(DIFF_W'(cx_r));
    dy_nxt = signed'(DIFF_W'({rowm, 4'b0000})) - signed'(DIFF_W'(cy_r));
  end

  logic              f1_v_r, f1_act_r, f1_dok_r, f1_cok_r;
  logic [3:0]        f1_idx_r, f1_step_r;
  logic [31:0]       f1_word_r;
  logic [CRD_W-1:0]  f1_row_r, f1_col_r, f1_qr_r, f1_qc_r;
  logic signed [DIFF_W-1:0] f1_dx_r, f1_dy_r;
  logic [15:0]       f1_depth_r, f1_fx_r, f1_fy_r;
  logic [7:0]        f1_b_r, f1_g_r, f1_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_act_r   <= in_action;
      f1_idx_r   <= in_idx;
      f1_word_r  <= in_word;
      f1_step_r  <= step_e;
      f1_row_r   <= rowm;
      f1_col_r   <= colm;
      f1_qr_r    <= qr_nxt;
      f1_qc_r    <= qc_nxt;
      f1_dx_r    <= dx_nxt;
      f1_dy_r    <= dy_nxt;
      f1_dok_r   <= (in_depth >= min_d_r) && (in_depth < max_d_r);
      f1_cok_r   <= (in_blue != 8'd0) || (in_green != 8'd0) || (in_red != 8'd0);
      f1_depth_r <= in_depth;
      f1_b_r     <= in_blue;
      f1_g_r     <= in_green;
      f1_rd_r    <= in_red;
      f1_fx_r    <= (fx_r == 16'd0) ? 16'd1 : fx_r;
      f1_fy_r    <= (fy_r == 16'd0) ? 16'd1 : fy_r;
    end
  end

  // stage 2: remainder test, magnitude times depth, rounded numerator
  logic [CRD_W-1:0]  rem_r_c, rem_c_c;
  logic              neg_x, neg_y;
  logic [MAG_W-1:0]  mag_x, mag_y;
  logic [PROD_W-1:0] prod_x, prod_y;
  dpw_tag_t          tag_nxt;
  logic [LANES-1:0][NUM_W-1:0] num_nxt;
  logic [LANES-1:0][DEN_W-1:0] den_nxt;

  always_comb begin
    rem_r_c = f1_row_r - CRD_W'(f1_qr_r * f1_step_r);
    rem_c_c = f1_col_r - CRD_W'(f1_qc_r * f1_step_r);
    neg_x   = f1_dx_r < 0;
    neg_y   = f1_dy_r < 0;
    mag_x   = MAG_W'(neg_x ? -f1_dx_r : f1_dx_r);
    mag_y   = MAG_W'(neg_y ? -f1_dy_r : f1_dy_r);
    prod_x  = PROD_W'(mag_x) * PROD_W'(f1_depth_r);
    prod_y  = PROD_W'(mag_y) * PROD_W'(f1_depth_r);
    den_nxt[0] = {f1_fx_r, 1'b0};
    den_nxt[1] = {f1_fy_r, 1'b0};
    num_nxt[0] = (NUM_W'(prod_x) << 1) + NUM_W'(f1_fx_r);
    num_nxt[1] = (NUM_W'(prod_y) << 1) + NUM_W'(f1_fy_r);
    tag_nxt.action = f1_act_r;
    tag_nxt.idx    = f1_idx_r;
    tag_nxt.word   = f1_word_r;
    tag_nxt.keep   = (rem_r_c == '0) && (rem_c_c == '0) && f1_dok_r && f1_cok_r;
    tag_nxt.neg_x  = neg_x;
    tag_nxt.neg_y  = neg_y;
    tag_nxt.depth  = f1_depth_r;
    tag_nxt.blue   = f1_b_r;
    tag_nxt.green  = f1_g_r;
    tag_nxt.red    = f1_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag_nxt;
      out_num <= num_nxt;
      out_den <= den_nxt;
    end
  end

endmodule

// ===== rtl/core/dpw_div.sv =====
// pipelined restoring divider, one quotient bit per stage, two lanes
`timescale 1ns / 1ps
module dpw_div import dpw_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  dpw_tag_t                    in_tag,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [LANES-1:0][DEN_W-1:0] in_den,
  output logic                        out_v,
  output dpw_tag_t                    out_tag,
  output logic [LANES-1:0][NUM_W-1:0] out_quo
);

  logic                        v_r   [NUM_W];
  dpw_tag_t                    tag_r [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_r [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] den_r [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] num_r [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] quo_r [NUM_W];

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic                        v_i;
    dpw_tag_t                    tag_i;
    logic [LANES-1:0][DEN_W-1:0] rem_i, den_i, rem_n;
    logic [LANES-1:0][NUM_W-1:0] num_i, quo_i, num_n, quo_n;

    if (g == 0) begin : g_first
      assign v_i   = in_v;
      assign tag_i = in_tag;
      assign rem_i = '0;
      assign den_i = in_den;
      assign num_i = in_num;
      assign quo_i = '0;
    end else begin : g_next
      assign v_i   = v_r[g-1];
      assign tag_i = tag_r[g-1];
      assign rem_i = rem_r[g-1];
      assign den_i = den_r[g-1];
      assign num_i = num_r[g-1];
      assign quo_i = quo_r[g-1];
    end

    always_comb begin
      logic [DEN_W:0] trial;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        trial    = {rem_i[l], num_i[l][NUM_W-1]};
        ge       = trial >= {1'b0, den_i[l]};
        rem_n[l] = ge ? DEN_W'(trial - {1'b0, den_i[l]}) : DEN_W'(trial);
        num_n[l] = num_i[l] << 1;
        quo_n[l] = {quo_i[l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[g] <= tag_i;
        rem_r[g] <= rem_n;
        den_r[g] <= den_i;
        num_r[g] <= num_n;
        quo_r[g] <= quo_n;
      end
    end
  end

  assign out_v   = v_r[NUM_W-1];
  assign out_tag = tag_r[NUM_W-1];
  assign out_quo = quo_r[NUM_W-1];

endmodule

// ===== rtl/core/dpw_back.sv =====
// back end: camera coordinates, transform store, rigid transform and output register
`timescale 1ns / 1ps
`include "depth_pixel_to_world_point_macros.svh"
module dpw_back import dpw_pkg::*; #(
  parameter int POSE_FRAC_BITS = POSE_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  dpw_tag_t                    in_tag,
  input  logic [LANES-1:0][NUM_W-1:0] in_quo,
  output logic                        out_v,
  output logic signed [CAM_W-1:0]     out_x,
  output logic signed [CAM_W-1:0]     out_y,
  output logic signed [CAM_W-1:0]     out_z,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_red
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (POSE_FRAC_BITS - 1);

  // stage c: saturate quotients and restore sign
  logic signed [CAM_W-1:0] cam_x_nxt, cam_y_nxt;

  always_comb begin
    logic [CAM_W-1:0] mx, my, lim_x, lim_y;
    // a negative coordinate reaches one further than a positive one
    lim_x = in_tag.neg_x ? SAT_MIN : SAT_MAX;
    lim_y = in_tag.neg_y ? SAT_MIN : SAT_MAX;
    mx = (in_quo[0] > NUM_W'(lim_x)) ? lim_x : in_quo[0][CAM_W-1:0];
    my = (in_quo[1] > NUM_W'(lim_y)) ? lim_y : in_quo[1][CAM_W-1:0];
    cam_x_nxt = in_tag.neg_x ? -signed'(mx) : signed'(mx);
    cam_y_nxt = in_tag.neg_y ? -signed'(my) : signed'(my);
  end

  logic                    c_v_r;
  dpw_tag_t                c_tag_r;
  logic signed [CAM_W-1:0] cam_x_r, cam_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_tag_r <= in_tag;
      cam_x_r <= cam_x_nxt;
      cam_y_r <= cam_y_nxt;
    end
  end

  // transform words are written in stream order, where pixels read them
  logic signed [31:0] tw_r [TW_N];
  logic               ld_en;

  assign ld_en = en && c_v_r && (c_tag_r.action == ACT_LOAD) && (c_tag_r.idx < 4'(TW_N));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TW_N; k++) tw_r[k] <= '0;
    end else if (ld_en) begin
      tw_r[c_tag_r.idx] <= c_tag_r.word;
    end
  end

  // stage p: products
  logic signed [CAM_W+31:0] pa_r [3];
  logic signed [CAM_W+31:0] pb_r [3];
  logic signed [48:0]       pc_r [3];
  logic signed [31:0]       pt_r [3];
  logic                     p_v_r;
  logic [7:0]               p_b_r, p_g_r, p_rd_r;
  logic signed [16:0]       depth_s;

  assign depth_s = signed'({1'b0, c_tag_r.depth});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= c_v_r && (c_tag_r.action == ACT_PIXEL) && c_tag_r.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= cam_x_r * tw_r[i*4];
        pb_r[i] <= cam_y_r * tw_r[i*4+1];
        pc_r[i] <= depth_s * tw_r[i*4+2];
        pt_r[i] <= tw_r[i*4+3];
      end
      p_b_r  <= c_tag_r.blue;
      p_g_r  <= c_tag_r.green;
      p_rd_r <= c_tag_r.red;
    end
  end

  // stage s: pairwise sums
  logic signed [ACC_W-1:0] sa_r [3];
  logic signed [ACC_W-1:0] sb_r [3];
  logic                    s_v_r;
  logic [7:0]              s_b_r, s_g_r, s_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sa_r[i] <= ACC_W'(pa_r[i]) + ACC_W'(pb_r[i]);
        sb_r[i] <= ACC_W'(pc_r[i]) + ACC_W'(pt_r[i]);
      end
      s_b_r  <= p_b_r;
      s_g_r  <= p_g_r;
      s_rd_r <= p_rd_r;
    end
  end

  // stage o: round half up, drop fraction, saturate
  logic signed [CAM_W-1:0] w_nxt [3];

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc      = sa_r[i] + sb_r[i] + HALF;
      w_nxt[i] = dpw_sat(acc >>> POSE_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x     <= w_nxt[0];
      out_y     <= w_nxt[1];
      out_z     <= w_nxt[2];
      out_blue  <= s_b_r;
      out_green <= s_g_r;
      out_red   <= s_rd_r;
    end
  end

  `DPW_ASSERT_NXT(a_tw_load, clk, rst_n, ld_en, tw_r[$past(c_tag_r.idx)] == $past(c_tag_r.word), "transform word not stored")
  `DPW_ASSERT_NXT(a_stall_hold, clk, rst_n, !en, out_v == $past(out_v) && $stable(out_x), "output moved during stall")
  `DPW_ASSERT_NXT(a_kept_out, clk, rst_n, en && s_v_r, out_v, "kept pixel lost at output")
  `DPW_ASSERT_IMP(a_no_load_out, clk, rst_n, en && c_v_r && c_tag_r.action == ACT_LOAD, ##1 !p_v_r, "load request produced a point")

endmodule

// ===== rtl/core/depth_pixel_to_world_point.sv =====
// top level: depth pixel back-projection and camera-to-world transform pipeline
// pipeline: 2 front, 36 divider and 4 back stages from input accept to result
// throughput: one request per cycle; the whole pipeline advances unless a result is held
// the divider pipeline (one quotient bit per stage) sets the latency
// reset: synchronous, active low; registers to defaults, transform words to zero
`timescale 1ns / 1ps
module depth_pixel_to_world_point import dpw_pkg::*; #(
  parameter int POSE_FRAC_BITS = POSE_FRAC_BITS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dpw_in_if.sink      in_ch,
  dpw_out_if.source   out_ch
);

  logic en;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic                        f_v;
  dpw_tag_t                    f_tag;
  logic [LANES-1:0][NUM_W-1:0] f_num;
  logic [LANES-1:0][DEN_W-1:0] f_den;

  dpw_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_v      (in_ch.valid),
    .in_action (in_ch.action),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_depth  (in_ch.depth_mm),
    .in_blue   (in_ch.blue),
    .in_green  (in_ch.green),
    .in_red    (in_ch.red),
    .in_idx    (in_ch.pose_index),
    .in_word   (in_ch.pose_word),
    .out_v     (f_v),
    .out_tag   (f_tag),
    .out_num   (f_num),
    .out_den   (f_den)
  );

  logic                        d_v;
  dpw_tag_t                    d_tag;
  logic [LANES-1:0][NUM_W-1:0] d_quo;

  dpw_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (f_v),
    .in_tag  (f_tag),
    .in_num  (f_num),
    .in_den  (f_den),
    .out_v   (d_v),
    .out_tag (d_tag),
    .out_quo (d_quo)
  );

  dpw_back #(.POSE_FRAC_BITS(POSE_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (d_v),
    .in_tag    (d_tag),
    .in_quo    (d_quo),
    .out_v     (out_ch.valid),
    .out_x     (out_ch.world_x),
    .out_y     (out_ch.world_y),
    .out_z     (out_ch.world_z),
    .out_blue  (out_ch.point_blue),
    .out_green (out_ch.point_green),
    .out_red   (out_ch.point_red)
  );

endmodule

// ===== tb/tb.sv =====
// testbench of the depth pixel to world point block: random and directed pixel stream checked against a predictor
`timescale 1ns / 1ps
module tb;
  import dpw_pkg::*;

  typedef struct {
    logic               action;
    logic [11:0]        row;
    logic [11:0]        col;
    logic [15:0]        depth_mm;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic [3:0]         pose_index;
    logic signed [31:0] pose_word;
  } pixel_req_t;

  typedef struct {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } world_point_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  dpw_in_if  in_ch();
  dpw_out_if out_ch();

  depth_pixel_to_world_point DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor state: step, intrinsics and window by register index, transform words
  logic [15:0]        reg_val [0:6];
  logic signed [31:0] pose_m [0:11];

  pixel_req_t   pixel_req_q[$];
  world_point_t point_q[$];

  logic in_taken;
  bit   failed;
  int   mismatches;
  bit   no_idle;
  int   stall_req;
  int   stall_seen;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // (16*pixel - centre) * depth / focal, ties away from zero
  function automatic longint cam_coord(longint pix, longint centre, longint depth,
                                       longint focal);
    longint diff;
    longint mag;
    longint den;
    longint q;
    diff = pix * 16 - centre;
    mag = (diff < 0 ? -diff : diff) * depth;
    den = (focal == 0) ? 1 : focal;
    q = (mag * 2 + den) / (den * 2);
    return sat24(diff < 0 ? -q : q);
  endfunction

  function automatic bit project_pixel(pixel_req_t p, output world_point_t pt);
    longint step;
    longint cam [0:2];
    longint acc;
    longint w [0:2];
    step = (reg_val[REG_STEP] == 0) ? 1 : reg_val[REG_STEP];
    pt = '{default: '0};
    if ((p.row % step) != 0 || (p.col % step) != 0) return 0;
    if (p.depth_mm < reg_val[REG_MIN_D] || p.depth_mm >= reg_val[REG_MAX_D]) return 0;
    if (p.blue == 0 && p.green == 0 && p.red == 0) return 0;
    cam[0] = cam_coord(p.col, reg_val[REG_CX], p.depth_mm, reg_val[REG_FX]);
    cam[1] = cam_coord(p.row, reg_val[REG_CY], p.depth_mm, reg_val[REG_FY]);
    cam[2] = p.depth_mm;
    for (int i = 0; i < 3; i++) begin
      acc = longint'(pose_m[i*4+3]) + longint'(pose_m[i*4]) * cam[0]
          + longint'(pose_m[i*4+1]) * cam[1] + longint'(pose_m[i*4+2]) * cam[2];
      // floor of value plus one half
      w[i] = sat24((acc + (64'sd1 << (POSE_FRAC_BITS_DEF - 1))) >>> POSE_FRAC_BITS_DEF);
    end
    pt.world_x = w[0][23:0];
    pt.world_y = w[1][23:0];
    pt.world_z = w[2][23:0];
    pt.blue = p.blue;
    pt.green = p.green;
    pt.red = p.red;
    return 1;
  endfunction

  // request driver
  always @(negedge clk) begin
    pixel_req_t p;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pixel_req_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 21)) begin
        p = pixel_req_q.pop_front();
        in_ch.action <= p.action;
        in_ch.row <= p.row;
        in_ch.col <= p.col;
        in_ch.depth_mm <= p.depth_mm;
        in_ch.blue <= p.blue;
        in_ch.green <= p.green;
        in_ch.red <= p.red;
        in_ch.pose_index <= p.pose_index;
        in_ch.pose_word <= p.pose_word;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result ready, with a long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // monitor: predict on accepted requests, check accepted points
  always @(posedge clk) begin
    pixel_req_t   p;
    world_point_t pt;
    world_point_t want;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.action = in_ch.action;
      p.row = in_ch.row;
      p.col = in_ch.col;
      p.depth_mm = in_ch.depth_mm;
      p.blue = in_ch.blue;
      p.green = in_ch.green;
      p.red = in_ch.red;
      p.pose_index = in_ch.pose_index;
      p.pose_word = in_ch.pose_word;
      if (p.action == ACT_LOAD) begin
        if (p.pose_index < TW_N) pose_m[p.pose_index] = p.pose_word;
      end else if (project_pixel(p, pt)) begin
        point_q = {point_q, pt};
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pt.world_x = out_ch.world_x;
      pt.world_y = out_ch.world_y;
      pt.world_z = out_ch.world_z;
      pt.blue = out_ch.point_blue;
      pt.green = out_ch.point_green;
      pt.red = out_ch.point_red;
      if (point_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected point x=%0d y=%0d z=%0d", pt.world_x,
                                       pt.world_y, pt.world_z);
      end else begin
        want = point_q.pop_front();
        if (pt.world_x !== want.world_x || pt.world_y !== want.world_y ||
            pt.world_z !== want.world_z || pt.blue !== want.blue ||
            pt.green !== want.green || pt.red !== want.red) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: want %0d %0d %0d bgr %0d %0d %0d, got %0d %0d %0d bgr %0d %0d %0d",
                     want.world_x, want.world_y, want.world_z, want.blue, want.green,
                     want.red, pt.world_x, pt.world_y, pt.world_z, pt.blue, pt.green,
                     pt.red);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    reg_val[idx] = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_camera(int step, int dmin, int dmax, int fx, int fy, int cx, int cy);
    write_reg(REG_STEP, step);
    write_reg(REG_MIN_D, dmin);
    write_reg(REG_MAX_D, dmax);
    write_reg(REG_FX, fx);
    write_reg(REG_FY, fy);
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
  endtask

  task automatic push_pixel(int row, int col, int depth, int b, int g, int r);
    pixel_req_t p;
    p.action = ACT_PIXEL;
    p.row = row;
    p.col = col;
    p.depth_mm = depth;
    p.blue = b;
    p.green = g;
    p.red = r;
    p.pose_index = $urandom;
    p.pose_word = $urandom;
    pixel_req_q = {pixel_req_q, p};
  endtask

  task automatic push_load(int idx, logic signed [31:0] word);
    pixel_req_t p;
    p.action = ACT_LOAD;
    p.row = $urandom;
    p.col = $urandom;
    p.depth_mm = $urandom;
    p.blue = $urandom;
    p.green = $urandom;
    p.red = $urandom;
    p.pose_index = idx;
    p.pose_word = word;
    pixel_req_q = {pixel_req_q, p};
  endtask

  task automatic load_identity(int tx, int ty, int tz);
    for (int k = 0; k < TW_N; k++) push_load(k, 0);
    push_load(0, 32'sh10000);
    push_load(5, 32'sh10000);
    push_load(10, 32'sh10000);
    push_load(3, tx);
    push_load(7, ty);
    push_load(11, tz);
  endtask

  // lets in-flight loads and dropped pixels drain too
  task automatic wait_drained();
    while (pixel_req_q.size() > 0 || in_ch.valid || point_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int step;
    int lo;
    int hi;
    int sel;
    step = (reg_val[REG_STEP] == 0) ? 1 : reg_val[REG_STEP];
    lo = reg_val[REG_MIN_D];
    hi = reg_val[REG_MAX_D];
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        if ($urandom_range(0, 1)) push_load($urandom_range(0, 15), $urandom);
        else push_load($urandom_range(0, 11), $urandom_range(0, 262143) - 131072);
      end else if (sel < 80 && lo < hi) begin
        push_pixel(step * $urandom_range(0, 4095 / step), step * $urandom_range(0, 4095 / step),
                   $urandom_range(lo, hi - 1), $urandom_range(1, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
      end else begin
        push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PIXEL;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.depth_mm = '0;
    in_ch.blue = '0;
    in_ch.green = '0;
    in_ch.red = '0;
    in_ch.pose_index = '0;
    in_ch.pose_word = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    failed = 1'b0;
    mismatches = 0;
    no_idle = 1'b0;
    stall_req = 0;
    stall_seen = 0;
    hold_left = 0;
    reg_val[REG_STEP] = 3;
    reg_val[REG_MIN_D] = 10;
    reg_val[REG_MAX_D] = 5000;
    reg_val[REG_FX] = 8400;
    reg_val[REG_FY] = 8400;
    reg_val[REG_CX] = 5120;
    reg_val[REG_CY] = 3840;
    for (int k = 0; k < TW_N; k++) pose_m[k] = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings: zero transform first, then identity
    push_pixel(0, 0, 100, 1, 2, 3);
    load_identity(1000, -2000, 3000);
    push_load(12, 32'sh7FFFFFFF);
    push_load(15, 32'sh80000000);
    push_pixel(0, 0, 10, 255, 255, 255);
    push_pixel(4095, 4095, 4999, 0, 0, 1);
    push_pixel(3, 3, 9, 10, 10, 10);
    push_pixel(3, 3, 5000, 10, 10, 10);
    push_pixel(6, 6, 65535, 10, 10, 10);
    push_pixel(6, 6, 0, 10, 10, 10);
    push_pixel(6, 9, 200, 0, 0, 0);
    push_pixel(4, 6, 200, 7, 7, 7);
    push_pixel(6, 4094, 300, 7, 0, 0);
    push_load(0, 32'sh7FFFFFFF);
    push_load(1, 32'sh80000000);
    push_load(3, 32'sh80000000);
    push_pixel(4095, 0, 4999, 9, 9, 9);
    push_pixel(0, 4095, 4999, 9, 9, 9);
    random_phase(100);
    wait_drained();

    set_camera(1, 0, 65535, 1, 65535, 0, 65535);
    load_identity(0, 0, 0);
    random_phase(130);
    wait_drained();

    // empty depth window, step zero
    set_camera(0, 65535, 0, 8400, 8400, 5120, 3840);
    random_phase(40);
    wait_drained();

    set_camera(8, 100, 3000, 8400, 8400, 32760, 24000);
    stall_req++;
    random_phase(130);
    wait_drained();

    // focal zero
    set_camera(5, 0, 65535, 0, 0, 65535, 0);
    random_phase(130);
    wait_drained();

    set_camera(2, 300, 8000, $urandom_range(1, 65535), $urandom_range(1, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_phase(130);
    wait_drained();

    no_idle = 1'b1;
    set_camera(1, 0, 65535, 9000, 9100, 5100, 3800);
    random_phase(130);
    wait_drained();
    no_idle = 1'b0;

    if (point_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
